### sv/sha256_pkg.sv
package sha256_pkg;

    localparam int unsigned CountWidth = 61;

    typedef logic [31:0] t_word;

    // Engine sequencer states.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ROUND  = 6'b000010,
        S_UPDATE = 6'b000100,
        S_PAD    = 6'b001000,
        S_EMIT   = 6'b010000,
        S_LEN    = 6'b100000
    } t_state;

    function automatic t_word f_init(input logic [2:0] idx);
        t_word v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic t_word f_k(input logic [5:0] r);
        t_word k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[r];
    endfunction

endpackage

### sv/sha256_if.sv
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### sv/sha256_hash_engine.sv
// SHA-256 over a byte stream.
// Input channel i_in: one beat carries data_byte, has_byte and end_of_message.
// A beat with has_byte set appends that byte to the message; a beat with
// end_of_message set closes the message, pads it and starts the digest.
// Output channel o_out: eight beats per message, digest words 0 to 7, the
// eighth flagged by last_word.
// A byte that does not fill a 64-byte block is stored; the input stays ready.
// The 64th byte starts a compression: one shared round unit runs 64 rounds,
// one per cycle, then an update step adds the result into the hash. End of
// message adds one or two compressions after padding, then eight output beats.
// The input is not ready while a compression runs or the digest is delivered.
// When the receiver stalls, the current digest word holds on the output until
// it is taken. Reset (synchronous, active low) returns the hash to its initial
// values and clears the byte count; the block buffer and round variables hold
// no defined value until written.
module sha256_hash_engine
    import sha256_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256_in_if.sink     i_in,
    sha256_out_if.source  o_out
);

    t_state                r_state;
    t_word                 r_h [8];
    t_word                 r_v [8];
    t_word                 r_w [16];
    logic [CountWidth-1:0] r_cnt;
    logic [5:0]            r_round;
    logic                  r_fin;     // compression belongs to the end of message
    logic                  r_need2;   // length goes in a second final block
    logic                  r_padded;  // padding of the final block is in place
    logic [2:0]            r_oidx;

    logic       w_acc;
    logic [5:0] w_pos;
    logic [3:0] w_idx;
    logic [1:0] w_lane;
    t_word      w_sched, w_s0, w_s1, w_t1, w_t2, w_x15, w_x2, w_wt;

    assign w_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_pos   = r_cnt[5:0];
    assign w_idx   = w_pos[5:2];
    assign w_lane  = w_pos[1:0];

    // Message schedule and round function, one round per cycle.
    assign w_x15 = r_w[r_round[3:0] + 4'd1];
    assign w_x2  = r_w[r_round[3:0] + 4'd14];
    assign w_s0  = {w_x15[6:0], w_x15[31:7]} ^ {w_x15[17:0], w_x15[31:18]} ^ (w_x15 >> 3);
    assign w_s1  = {w_x2[16:0], w_x2[31:17]} ^ {w_x2[18:0], w_x2[31:19]} ^ (w_x2 >> 10);
    assign w_sched = r_w[r_round[3:0]] + w_s0 + r_w[r_round[3:0] + 4'd9] + w_s1;
    assign w_wt  = (r_round < 6'd16) ? r_w[r_round[3:0]] : w_sched;
    assign w_t1  = r_v[7]
                 + ({r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
                    ^ {r_v[4][24:0], r_v[4][31:25]})
                 + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + f_k(r_round) + w_wt;
    assign w_t2  = ({r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
                    ^ {r_v[0][21:0], r_v[0][31:22]})
                 + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign o_out.valid       = (r_state == S_EMIT);
    assign o_out.digest_word = r_h[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd7);

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_round  <= '0;
            r_fin    <= 1'b0;
            r_need2  <= 1'b0;
            r_padded <= 1'b0;
            r_oidx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= f_init(3'(i));
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_in.has_byte) begin
                            if (w_lane == 2'd0) begin
                                r_w[w_idx] <= {i_in.data_byte, 24'h0};
                            end else begin
                                r_w[w_idx] <= r_w[w_idx]
                                    | (t_word'(i_in.data_byte) << (5'd24 - {w_lane, 3'b000}));
                            end
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_fin    <= i_in.end_of_message;
                        r_padded <= 1'b0;
                        if (i_in.has_byte && w_pos == 6'd63) begin
                            r_v   <= r_h;
                            r_round <= '0;
                            r_state <= S_ROUND;
                        end else if (i_in.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_ROUND: begin
                    if (r_round >= 6'd16) begin
                        r_w[r_round[3:0]] <= w_sched;
                    end
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_round <= r_round + 1'b1;
                    if (r_round == 6'd63) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (!r_padded) begin
                        // A full data block closed the message; padding follows.
                        r_state <= S_PAD;
                    end else if (r_need2) begin
                        r_need2 <= 1'b0;
                        r_state <= S_LEN;
                    end else begin
                        r_oidx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_PAD: begin
                    // Append 0x80, clear the tail and place the length if it fits.
                    for (int i = 0; i < 16; i++) begin
                        if (4'(i) == w_idx) begin
                            if (w_lane == 2'd0) begin
                                r_w[i] <= 32'h8000_0000;
                            end else begin
                                r_w[i] <= r_w[i] | (32'h80 << (5'd24 - {w_lane, 3'b000}));
                            end
                        end else if (4'(i) > w_idx) begin
                            r_w[i] <= '0;
                        end
                    end
                    if (w_pos < 6'd56) begin
                        r_w[14] <= {r_cnt[CountWidth-1:29]};
                        r_w[15] <= {r_cnt[28:0], 3'b000};
                        r_need2 <= 1'b0;
                    end else begin
                        r_need2 <= 1'b1;
                    end
                    r_padded <= 1'b1;
                    r_v      <= r_h;
                    r_round  <= '0;
                    r_state  <= S_ROUND;
                end
                S_LEN: begin
                    for (int i = 0; i < 14; i++) begin
                        r_w[i] <= '0;
                    end
                    r_w[14] <= {r_cnt[CountWidth-1:29]};
                    r_w[15] <= {r_cnt[28:0], 3'b000};
                    r_v     <= r_h;
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_cnt <= '0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= f_init(3'(i));
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks on the sequencer.
    a_round_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round != 6'd63) |=> (r_state == S_ROUND))
        else $error("round sequence broken");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == 6'd63) |=> (r_state == S_UPDATE))
        else $error("update missed after last round");
    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_word) |=>
            (o_out.valid && o_out.word_index == $past(o_out.word_index) + 3'd1))
        else $error("digest words out of order");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input ready while busy");

endmodule

### bench/sha256_tb_if.sv
`timescale 1ns / 100ps

// Testbench-side view of the two channels. The bench instantiates the RTL
// interfaces from sv/sha256_if.sv directly; this file holds the beat structs
// of the predictor and checker and keeps the folder's timescale consistent.
package sha256_tb_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_beat;
endpackage

### bench/tb_sha256_hash_engine.sv
`timescale 1ns / 100ps

module tb_sha256_hash_engine;
    import sha256_pkg::*;
    import sha256_tb_pkg::*;

    localparam int unsigned CycleLimit = 400000;

    logic i_clk;
    logic i_rst_n;
    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_hash_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Round constants and initial hash of the digest predictor.
    logic [31:0] round_k [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    logic [31:0] start_hash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Predictor state.
    logic [31:0] chain_hash [8];
    logic [31:0] block_buf [16];
    logic [60:0] byte_count;
    t_digest_beat digest_queue [$];

    int unsigned failures;
    int unsigned beats_sent;
    int unsigned digests_seen;
    int unsigned cycle_count;
    logic        quiet_phase;
    logic        hold_request;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of block_buf into chain_hash.
    task automatic compress_block();
        logic [31:0] v [8];
        logic [31:0] w [64];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
    endtask

    // Big-endian placement of a byte into the block buffer.
    task automatic place_byte(input int pos, input logic [7:0] b);
        if ((pos & 3) == 0) block_buf[pos >> 2] = {b, 24'h0};
        else block_buf[pos >> 2] |= 32'(b) << (24 - 8 * (pos & 3));
    endtask

    // Absorb one accepted beat and queue any digest words it finishes.
    task automatic absorb_beat(input t_in_beat bt);
        int pos;
        logic [63:0] bits;
        t_digest_beat d;
        if (bt.has_byte) begin
            pos = int'(byte_count[5:0]);
            place_byte(pos, bt.data_byte);
            byte_count = byte_count + 61'd1;
            if (pos == 63) compress_block();
        end
        if (bt.end_of_message) begin
            pos = int'(byte_count[5:0]);
            bits = {byte_count, 3'b000};
            place_byte(pos, 8'h80);
            for (int i = (pos >> 2) + 1; i < 16; i++) block_buf[i] = '0;
            if (pos + 1 > 56) begin
                compress_block();
                for (int i = 0; i < 14; i++) block_buf[i] = '0;
            end
            block_buf[14] = bits[63:32];
            block_buf[15] = bits[31:0];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                d.digest_word = chain_hash[i];
                d.word_index  = 3'(i);
                d.last_word   = (i == 7);
                digest_queue.push_back(d);
            end
            for (int i = 0; i < 8; i++) chain_hash[i] = start_hash[i];
            byte_count = '0;
        end
    endtask

    // Watch input beats at the rising edge and feed the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            absorb_beat({in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message});
        end
    end

    // Check each digest beat against the oldest expected word.
    always @(posedge i_clk) begin
        t_digest_beat exp_d;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected digest beat, actual word %h index %0d last %0b",
                         $time, out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                failures++;
            end else begin
                exp_d = digest_queue.pop_front();
                if (exp_d.digest_word !== out_ch.digest_word ||
                    exp_d.word_index !== out_ch.word_index ||
                    exp_d.last_word !== out_ch.last_word) begin
                    $display("%0t: digest mismatch, expected %h/%0d/%0b actual %h/%0d/%0b",
                             $time, exp_d.digest_word, exp_d.word_index, exp_d.last_word,
                             out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                    failures++;
                end
                if (exp_d.last_word) digests_seen++;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        int unsigned gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                for (int i = 0; i < 300; i++) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 7);
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one beat and hold it until accepted; random gap ahead of it.
    // Valid stays high after acceptance until the next beat or wait_drained.
    task automatic send_beat(input logic [7:0] b, input logic hb, input logic eom);
        int unsigned gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.has_byte       <= hb;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected digest word has come.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (digest_queue.size() != 0) @(negedge i_clk);
    endtask

    // Message of len random bytes with random empty beats mixed in.
    task automatic send_message(input int len, input logic empty_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
        end
        if (empty_end || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    typedef struct {
        logic [7:0]  b;
        logic        hb;
        logic        eom;
        logic [31:0] word0;
        logic        known;
    } t_row;

    // Directed rows: empty message, "abc", flag combinations, byte extremes.
    t_row directed [] = '{
        '{8'h00, 1'b0, 1'b1, 32'he3b0c442, 1'b1},
        '{8'h61, 1'b1, 1'b0, 32'h0, 1'b0},
        '{8'h62, 1'b1, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h63, 1'b1, 1'b1, 32'hba7816bf, 1'b1},
        '{8'hff, 1'b1, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b1, 1'b0, 32'h0, 1'b0},
        '{8'h55, 1'b0, 1'b1, 32'h0, 1'b0},
        '{8'haa, 1'b1, 1'b1, 32'h0, 1'b0},
        '{8'hff, 1'b1, 1'b1, 32'h0, 1'b0}
    };

    initial begin
        int unsigned qsize;
        failures = 0; beats_sent = 0; digests_seen = 0; cycle_count = 0;
        quiet_phase = 0; hold_request = 0;
        for (int i = 0; i < 8; i++) chain_hash[i] = start_hash[i];
        for (int i = 0; i < 16; i++) block_buf[i] = '0;
        byte_count = '0;
        in_ch.valid = 1'b0; in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0; in_ch.end_of_message = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table; known first words are checked when predicted.
        foreach (directed[k]) begin
            qsize = digest_queue.size();
            send_beat(directed[k].b, directed[k].hb, directed[k].eom);
            if (directed[k].known && digest_queue[qsize].digest_word !== directed[k].word0) begin
                $display("%0t: known digest mismatch, expected %h actual %h",
                         $time, directed[k].word0, digest_queue[qsize].digest_word);
                failures++;
            end
        end
        // Padding boundaries: length in a second final block, and a full
        // block whose last byte ends the message.
        send_message(56, 1'b1);
        wait_drained();
        send_message(64, 1'b0);

        // Long receiver stall while the sender keeps offering messages.
        hold_request = 1'b1;
        for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3), $urandom_range(0, 1));
        wait_drained();

        // Random messages, the tail with no idling.
        for (int m = 0; m < 6; m++) begin
            if (m == 4) quiet_phase = 1'b1;
            send_message($urandom_range(0, 4), $urandom_range(0, 3) == 0);
        end
        wait_drained();
        repeat (200) @(negedge i_clk);

        $display("Sent %0d input beats and checked %0d digests, block edges and stalls included.",
                 beats_sent, digests_seen);
        if (failures == 0 && digest_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
